// File: hw/rtl/tts_pkg.sv
package tts_pkg;

	localparam int NUM_TASKS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int IDX_IN_W   = 4;
	localparam int PRIO_W     = 16;
	localparam int REM_W      = 16;
	localparam int LFSR_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 8;

	localparam logic [LFSR_W-1:0] LFSR_TAPS     = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED_RST = 16'd44257;

	// command codes carried in tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_SCAN_DRAIN,
		ST_DECIDE,
		ST_REFILL,
		ST_FINISH
	} tts_state_t;

	typedef struct packed {
		logic wr_entry;    // item is an entry write, store it now
		logic tick_start;  // item is a tick
		logic rd_cur;      // read the current task's counter
		logic mark_sched;  // this tick reschedules
		logic scan_init;
		logic scan_issue;
		logic refill_init;
		logic refill_step;
		logic commit;      // load the result register
	} tts_cmd_t;

	typedef struct packed {
		logic need_sched;
		logic issue_last;
		logic found;
		logic refilled;
	} tts_sts_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage

// File: hw/rtl/tts_ctrl.sv
module tts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_command,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tts_pkg::tts_sts_t sts,
	output tts_pkg::tts_cmd_t cmd
);
	import tts_pkg::*;

	tts_state_t state_q, state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_command == CMD_TICK) ? ST_CHK_RD : ST_FINISH;
				end
			end
			ST_CHK_RD:     state_d = ST_CHK;
			ST_CHK:        state_d = sts.need_sched ? ST_SCAN_INIT : ST_FINISH;
			ST_SCAN_INIT:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.issue_last) begin
					state_d = ST_SCAN_DRAIN;
				end
			end
			ST_SCAN_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = (sts.found || sts.refilled) ? ST_FINISH : ST_REFILL;
			end
			ST_REFILL: begin
				if (sts.issue_last) begin
					state_d = ST_SCAN_INIT;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_entry   = accept && (in_command == CMD_WRITE);
				cmd.tick_start = accept && (in_command == CMD_TICK);
			end
			ST_CHK_RD:    cmd.rd_cur      = 1'b1;
			ST_CHK:       cmd.mark_sched  = sts.need_sched;
			ST_SCAN_INIT: cmd.scan_init   = 1'b1;
			ST_SCAN:      cmd.scan_issue  = 1'b1;
			ST_DECIDE:    cmd.refill_init = !(sts.found || sts.refilled);
			ST_REFILL:    cmd.refill_step = 1'b1;
			ST_FINISH:    cmd.commit      = slot_free;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a second refill would mean the decide step lost track of the first one
	a_one_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && sts.refilled) |=> (state_q == ST_FINISH))
		else $error("second refill pass started in one tick");

	// result is never loaded over an item that was not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped");

	// scan and refill only run inside a tick that reschedules
	a_scan_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && !sts.need_sched) |=> (state_q == ST_FINISH))
		else $error("scan started although current task still has time");

endmodule

// File: hw/rtl/tts_dpath.sv
module tts_dpath #(
	parameter int NUM_TASKS  = tts_pkg::NUM_TASKS_DEF,
	parameter int COUNT_BITS = tts_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tts_pkg::tts_cmd_t             cmd,
	output tts_pkg::tts_sts_t             sts,
	input  logic [tts_pkg::IDX_IN_W-1:0]  task_index,
	input  logic                          runnable,
	input  logic [tts_pkg::REM_W-1:0]     remaining,
	input  logic [tts_pkg::PRIO_W-1:0]    prio,
	input  logic                          cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [tts_pkg::IDX_IN_W-1:0]  current_index,
	output logic                          switched,
	output logic                          refilled,
	output logic                          none_ready
);
	import tts_pkg::*;

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// table memories, valid bits stand in for the reset value of zero
	logic [COUNT_BITS-1:0] cnt_mem [NUM_TASKS];
	logic [PRIO_W-1:0]     pri_mem [NUM_TASKS];
	logic                  run_mem [NUM_TASKS];
	logic [NUM_TASKS-1:0]  cnt_vld_q;
	logic [NUM_TASKS-1:0]  rp_vld_q;

	logic                  mode_q;
	logic [LFSR_W-1:0]     lfsr_q;
	logic [LFSR_W-1:0]     lfsr_nxt;

	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  sched_q;
	logic                  refill_q;

	logic                  found_q;
	logic [IDX_W-1:0]      best_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [PRIO_W-1:0]     best_pri_q;

	logic [IDX_W-1:0]      rd_addr;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic [PRIO_W-1:0]     pri_rd_s1;
	logic                  run_rd_s1;
	logic                  cvld_s1;
	logic                  rpvld_s1;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic [COUNT_BITS-1:0] c_eff;
	logic [PRIO_W-1:0]     p_eff;
	logic                  r_eff;
	logic                  qualifies;
	logic                  better;

	logic                  wr_in_range;
	logic [IDX_W-1:0]      wr_addr;
	logic                  cnt_we;
	logic [IDX_W-1:0]      cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;

	logic [IDX_IN_W-1:0]   res_cur_q;
	logic                  res_sw_q;
	logic                  res_refill_q;
	logic                  res_none_q;
	logic                  take_best;

	assign wr_in_range = ({5'b0, task_index} < 9'(NUM_TASKS));
	assign wr_addr     = IDX_W'(task_index);
	assign lfsr_nxt    = lfsr_next(lfsr_q);

	assign cnt_we = (cmd.wr_entry && wr_in_range) || cmd.refill_step;
	assign cnt_wa = cmd.refill_step ? idx_q : wr_addr;
	assign cnt_wd = cmd.refill_step ? COUNT_BITS'(lfsr_nxt) : COUNT_BITS'(remaining);

	assign rd_addr = cmd.rd_cur ? cur_q : idx_q;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cmd.wr_entry && wr_in_range) begin
			pri_mem[wr_addr] <= prio;
			run_mem[wr_addr] <= runnable;
		end
	end

	always_ff @(posedge clk) begin
		cnt_rd_s1 <= cnt_mem[rd_addr];
		pri_rd_s1 <= pri_mem[rd_addr];
		run_rd_s1 <= run_mem[rd_addr];
		cvld_s1   <= cnt_vld_q[rd_addr];
		rpvld_s1  <= rp_vld_q[rd_addr];
		idx_s1    <= rd_addr;
	end

	assign c_eff = cvld_s1 ? cnt_rd_s1 : '0;
	assign p_eff = rpvld_s1 ? pri_rd_s1 : '0;
	assign r_eff = rpvld_s1 && run_rd_s1;

	assign qualifies = r_eff && (c_eff != '0);

	always_comb begin
		if (!found_q) begin
			better = 1'b1;
		end else if (mode_q) begin
			better = (p_eff > best_pri_q) || ((p_eff == best_pri_q) && (c_eff < best_cnt_q));
		end else begin
			better = (c_eff < best_cnt_q);
		end
	end

	assign sts.need_sched = (cur_q == '0) || (c_eff == '0);
	assign sts.issue_last = (idx_q == IDX_W'(NUM_TASKS - 1));
	assign sts.found      = found_q;
	assign sts.refilled   = refill_q;

	assign take_best = sched_q && found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q  <= '0;
			rp_vld_q   <= '0;
			mode_q     <= 1'b0;
			lfsr_q     <= LFSR_SEED_RST;
			cur_q      <= '0;
			idx_q      <= '0;
			sched_q    <= 1'b0;
			refill_q   <= 1'b0;
			found_q    <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_issue;
			if (cnt_we) begin
				cnt_vld_q[cnt_wa] <= 1'b1;
			end
			if (cmd.wr_entry && wr_in_range) begin
				rp_vld_q[wr_addr] <= 1'b1;
			end
			if (cfg_we && cfg_index == REG_SCHED_MODE) begin
				mode_q <= cfg_data[0];
			end
			// zero seed would lock the LFSR, so it loads one instead
			if (cfg_we && cfg_index == REG_RANDOM_SEED) begin
				lfsr_q <= (cfg_data != '0) ? LFSR_W'(cfg_data) : LFSR_W'(1);
			end else if (cmd.refill_step) begin
				lfsr_q <= lfsr_nxt;
			end
			if (cmd.wr_entry || cmd.tick_start) begin
				sched_q  <= 1'b0;
				refill_q <= 1'b0;
			end
			if (cmd.mark_sched) begin
				sched_q <= 1'b1;
			end
			if (cmd.refill_init) begin
				refill_q <= 1'b1;
			end
			if (cmd.scan_init || cmd.refill_init) begin
				idx_q <= IDX_W'(1);
			end else if (cmd.scan_issue || cmd.refill_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (vld_s1 && qualifies && better) begin
				found_q <= 1'b1;
			end
			if (cmd.commit && take_best) begin
				cur_q <= best_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && qualifies && better) begin
			best_q     <= idx_s1;
			best_cnt_q <= c_eff;
			best_pri_q <= p_eff;
		end
		if (cmd.commit) begin
			res_cur_q    <= take_best ? IDX_IN_W'(best_q) : IDX_IN_W'(cur_q);
			res_sw_q     <= take_best && (best_q != cur_q);
			res_refill_q <= refill_q;
			res_none_q   <= sched_q && !found_q;
		end
	end

	assign current_index = res_cur_q;
	assign switched      = res_sw_q;
	assign refilled      = res_refill_q;
	assign none_ready    = res_none_q;

	a_cur_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_q} < (IDX_W+1)'(NUM_TASKS)))
		else $error("current task outside the table");

	a_idle_never_best: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && take_best) |-> (best_q != '0))
		else $error("idle task chosen");

	a_scan_skips_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_issue || cmd.refill_step) |-> (idx_q != '0))
		else $error("scan or refill touched the idle entry");

endmodule

// File: hw/rtl/task_table_scheduler_unit.sv
// channel   | direction | handshake              | payload
// s_axis    | in        | s_axis_tvalid/tready   | tuser command, tdata entry fields
// m_axis    | out       | m_axis_tvalid/tready   | tdata index and flags
// cfg       | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A write item stores its entry and finishes. A tick whose current task still
// has time only reads that task's counter; a rescheduling tick scans the table
// through one memory read port, and scans it again after a refill.
// Reset clears the table through per-entry valid bits, no clearing pass.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
module task_table_scheduler_unit #(
	parameter int NUM_TASKS  = tts_pkg::NUM_TASKS_DEF,
	parameter int COUNT_BITS = tts_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [3:0] task_index, [4] runnable, [20:5] remaining, [36:21] prio
	input  logic [tts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] current_index, [4] switched, [5] refilled, [6] none_ready
	output logic [tts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tts_pkg::*;

	tts_cmd_t            cmd;
	tts_sts_t            sts;
	logic [IDX_IN_W-1:0] current_index;
	logic                switched;
	logic                refilled;
	logic                none_ready;

	assign cfg_ready = 1'b1;

	tts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tts_dpath #(
		.NUM_TASKS  (NUM_TASKS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.task_index    (s_axis_tdata[3:0]),
		.runnable      (s_axis_tdata[4]),
		.remaining     (s_axis_tdata[20:5]),
		.prio          (s_axis_tdata[36:21]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.current_index (current_index),
		.switched      (switched),
		.refilled      (refilled),
		.none_ready    (none_ready)
	);

	assign m_axis_tdata = {1'b0, none_ready, refilled, switched, current_index};

endmodule

// File: tb/testbench.sv
module testbench;
	import tts_pkg::*;

	localparam int NUM_T            = NUM_TASKS_DEF;
	localparam int LATENCY_CYCLES   = 3 * NUM_TASKS_DEF + 8;
	localparam int DRAIN_LIMIT      = 5000;
	localparam int LONG_HOLD_AT     = 60;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS      = 100;
	localparam int WATCHDOG_TIME    = 20 * 400000;

	// indexes past the register file; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic        command;
		logic [3:0]  task_index;
		logic        runnable;
		logic [15:0] remaining;
		logic [15:0] prio;
	} sched_item_t;

	typedef struct packed {
		logic [3:0] cur;
		logic       switched;
		logic       refilled;
		logic       none_ready;
	} sched_result_t;

	class sched_checker;
		logic          run_flag [NUM_T];
		logic [15:0]   count    [NUM_T];
		logic [15:0]   prio     [NUM_T];
		logic [3:0]    cur_task;
		logic [15:0]   lfsr;
		logic          prio_mode;
		sched_result_t due_results[$];
		int            errors;

		function new();
			for (int i = 0; i < NUM_T; i++) begin
				run_flag[i] = 1'b0;
				count[i]    = '0;
				prio[i]     = '0;
			end
			cur_task  = '0;
			lfsr      = LFSR_SEED_RST;
			prio_mode = 1'b0;
			errors    = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SCHED_MODE: begin
					prio_mode = val[0];
				end
				REG_RANDOM_SEED: begin
					lfsr = (val == '0) ? 16'd1 : val;
				end
				default: begin
				end
			endcase
		endfunction

		function logic [3:0] pick_next_task();
			logic [3:0]  best;
			logic [15:0] best_cnt;
			logic [15:0] best_pri;
			logic        found;
			logic        better;
			best     = '0;
			best_cnt = '0;
			best_pri = '0;
			found    = 1'b0;
			for (int i = 1; i < NUM_T; i++) begin
				if (run_flag[i] && count[i] != 0) begin
					if (!found)
						better = 1'b1;
					else if (prio_mode)
						better = (prio[i] > best_pri) ||
							(prio[i] == best_pri && count[i] < best_cnt);
					else
						better = count[i] < best_cnt;
					if (better) begin
						found    = 1'b1;
						best     = 4'(i);
						best_cnt = count[i];
						best_pri = prio[i];
					end
				end
			end
			return best;
		endfunction

		function void note_item(sched_item_t it);
			sched_result_t r;
			logic [3:0]    nxt;
			r = '0;
			if (it.command == CMD_WRITE) begin
				run_flag[it.task_index] = it.runnable;
				count[it.task_index]    = it.remaining;
				prio[it.task_index]     = it.prio;
			end else if (cur_task == 0 || count[cur_task] == 0) begin
				nxt = pick_next_task();
				if (nxt == 0) begin
					// refill in index order, one LFSR step per entry
					r.refilled = 1'b1;
					for (int i = 1; i < NUM_T; i++) begin
						lfsr     = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
						count[i] = lfsr;
					end
					nxt = pick_next_task();
				end
				if (nxt == 0) begin
					r.none_ready = 1'b1;
				end else if (nxt != cur_task) begin
					cur_task   = nxt;
					r.switched = 1'b1;
				end
			end
			r.cur = cur_task;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			sched_result_t exp_r;
			if (due_results.size() == 0) begin
				$error("result %h with no item outstanding", word);
				errors++;
				return;
			end
			exp_r = due_results.pop_front();
			if (word[3:0] !== exp_r.cur) begin
				$error("current_index: expected %0d, got %0d", exp_r.cur, word[3:0]);
				errors++;
			end
			if (word[4] !== exp_r.switched) begin
				$error("switched: expected %0b, got %0b", exp_r.switched, word[4]);
				errors++;
			end
			if (word[5] !== exp_r.refilled) begin
				$error("refilled: expected %0b, got %0b", exp_r.refilled, word[5]);
				errors++;
			end
			if (word[6] !== exp_r.none_ready) begin
				$error("none_ready: expected %0b, got %0b", exp_r.none_ready, word[6]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sched_checker sb;
	logic         quiet_end;
	logic         tx_gap_on;

	task_table_scheduler_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_TIME);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic sched_item_t mk_item(logic cmd, logic [3:0] idx, logic run,
		logic [15:0] rem, logic [15:0] pri);
		sched_item_t it;
		it.command    = cmd;
		it.task_index = idx;
		it.runnable   = run;
		it.remaining  = rem;
		it.prio       = pri;
		return it;
	endfunction

	function automatic logic [15:0] random_prio();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom_range(0, 3));
			1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sched_item_t random_item();
		sched_item_t it;
		it.command = ($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_WRITE;
		// hitting the current task often is what lets its count run out
		it.task_index = ($urandom_range(0, 3) == 0) ? sb.cur_task : 4'($urandom_range(0, 15));
		it.runnable   = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 5))
			0, 1:    it.remaining = 16'd0;
			2:       it.remaining = 16'($urandom_range(1, 4));
			3:       it.remaining = 16'hFFFF;
			default: it.remaining = 16'($urandom);
		endcase
		it.prio = random_prio();
		return it;
	endfunction

	function automatic sched_item_t tick_item();
		sched_item_t it;
		it         = random_item();
		it.command = CMD_TICK;
		return it;
	endfunction

	task automatic send_item(input sched_item_t it);
		if (tx_gap_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.command;
		s_axis_tdata  <= {3'b000, it.prio, it.remaining, it.runnable, it.task_index};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_reg(idx, val);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n_items);
		int sent;
		int kind;
		int len;
		sent = 0;
		while (sent < n_items) begin
			tx_gap_on = !quiet_end && ($urandom_range(0, 2) != 0);
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				// nothing runnable: the tick refills and still finds no task
				for (int i = 1; i < NUM_T; i++)
					send_item(mk_item(CMD_WRITE, 4'(i), 1'b0,
						(i == sb.cur_task || $urandom_range(0, 1)) ? 16'd0 : 16'($urandom),
						random_prio()));
				send_item(tick_item());
				sent += NUM_T;
			end else if (kind < 30) begin
				// runnable entries all at zero count, tick must refill and pick one if any exists
				for (int i = 1; i < NUM_T; i++)
					send_item(mk_item(CMD_WRITE, 4'(i), $urandom_range(0, 3) != 0, 16'd0,
						random_prio()));
				send_item(tick_item());
				sent += NUM_T;
			end else begin
				len = $urandom_range(4, 10);
				repeat (len) send_item(random_item());
				sent += len;
			end
		end
	endtask

	initial begin : result_sink
		int   hold_left;
		int   mode_left;
		int   seen;
		logic stalling;
		logic long_done;
		hold_left = 0;
		mode_left = 0;
		seen      = 0;
		stalling  = 1'b0;
		long_done = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
				seen++;
			end
			// one long hold-off so the block backs up into its input
			if (!long_done && seen == LONG_HOLD_AT) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				stalling  = 1'($urandom_range(0, 1));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stalling && !quiet_end && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		sb        = new();
		quiet_end = 1'b0;
		tx_gap_on = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_WRITE;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_SCHED_MODE;
		cfg_data      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: shortest count first, default seed
		tx_gap_on = 1'b1;
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd0, 1'b1, 16'd1, 16'hFFFF));
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF));
		send_item(mk_item(CMD_WRITE, 4'd5, 1'b1, 16'd3, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd9, 1'b1, 16'd3, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd3, 1'b1, 16'd0, 16'hFFFF));
		send_item(mk_item(CMD_TICK, 4'hF, 1'b1, 16'hFFFF, 16'hFFFF));
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd5, 1'b1, 16'd0, 16'd0));
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd9, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd15, 1'b1, 16'd0, 16'hFFFF));
		send_item(mk_item(CMD_WRITE, 4'd5, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, sb.cur_task, 1'b1, 16'd0, 16'h00FF));
		send_item(mk_item(CMD_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
		send_item(mk_item(CMD_WRITE, 4'd6, 1'b0, 16'hFFFF, 16'd1));
		send_item(mk_item(CMD_WRITE, 4'd0, 1'b0, 16'd0, 16'd0));
		run_random(PHASE_ITEMS);
		wait_drained();

		// priority mode; upper data bits of the mode write are ignored
		write_reg(REG_SCHED_MODE, 16'hFFFF);
		write_reg(REG_RANDOM_SEED, 16'd1);
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		wait_drained();

		write_reg(REG_SCHED_MODE, 16'hFFFE);
		write_reg(REG_RANDOM_SEED, 16'hFFFF);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'($urandom));
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		wait_drained();

		// zero seed loads the LFSR with one; last part runs without idling
		write_reg(REG_SCHED_MODE, 16'h0001);
		write_reg(REG_RANDOM_SEED, 16'h0000);
		cfg_valid <= 1'b0;
		quiet_end = 1'b1;
		run_random(PHASE_ITEMS);
		wait_drained();

		if (sb.pending() != 0)
			$error("%0d results never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
